[sv/ezr_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers for the ZXY Euler-to-matrix unit.
package ezr_pkg;

  // Defaults for the top-level parameters
  localparam int ANGLE_BITS_DEF    = 16;
  localparam int OUT_FRAC_BITS_DEF = 14;
  localparam int CORDIC_STEPS_DEF  = 16;

  // Internal number formats: angles as a 32-bit turn, trig values in Q30
  localparam int TURN_W = 32;
  localparam int CW     = 33;  // CORDIC datapath width (x, y, z)
  localparam int TRIG_W = 32;  // sine/cosine and product width
  localparam int Q_FRAC = 30;

  localparam logic signed [CW-1:0] GAIN_INV = CW'(652032874);

  // atan(2^-i) as a fraction of a full 2^32 turn
  localparam logic signed [CW-1:0] ATAN_TURNS [0:31] = '{
    CW'(536870912), CW'(316933406), CW'(167458907), CW'(85004756),
    CW'(42667331),  CW'(21354465),  CW'(10679838),  CW'(5340245),
    CW'(2670163),   CW'(1335087),   CW'(667544),    CW'(333772),
    CW'(166886),    CW'(83443),     CW'(41722),     CW'(20861),
    CW'(10430),     CW'(5215),      CW'(2608),      CW'(1304),
    CW'(652),       CW'(326),       CW'(163),       CW'(81),
    CW'(41),        CW'(20),        CW'(10),        CW'(5),
    CW'(3),         CW'(1),         CW'(1),         CW'(0)
  };

  localparam logic signed [2*TRIG_W-1:0] MUL_RND = (2*TRIG_W)'(1) << (Q_FRAC - 1);

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] c;
    logic signed [TRIG_W-1:0] s;
  } trig_t;

  // Q30 product, rounded half up
  function automatic logic signed [TRIG_W-1:0] mul_q(input logic signed [TRIG_W-1:0] a,
                                                     input logic signed [TRIG_W-1:0] b);
    logic signed [2*TRIG_W-1:0] p;
    p = a * b + MUL_RND;
    return TRIG_W'(p >>> Q_FRAC);
  endfunction

endpackage

[sv/ezr_cordic_lane.sv]
`timescale 1ns / 1ps
// Pipelined rotation-mode CORDIC lane: one binary angle to its cosine and sine.
module ezr_cordic_lane #(
  parameter int ANGLE_BITS   = ezr_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STEPS = ezr_pkg::CORDIC_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [ANGLE_BITS-1:0] angle,
  output ezr_pkg::trig_t        trig_o
);
  import ezr_pkg::*;

  logic [TURN_W-1:0] turn, turn_bias, fold;
  quad_t             quad;

  logic signed [CW-1:0] x_r [0:CORDIC_STEPS];
  logic signed [CW-1:0] y_r [0:CORDIC_STEPS];
  logic signed [CW-1:0] z_r [0:CORDIC_STEPS];
  quad_t                q_r [0:CORDIC_STEPS];
  trig_t                trig_r;

  // fold into [-pi/4, pi/4) plus a quarter-turn count
  always_comb begin
    turn      = TURN_W'(angle) << (TURN_W - ANGLE_BITS);
    turn_bias = turn + (TURN_W'(1) << (TURN_W - 3));
    quad      = quad_t'(turn_bias[TURN_W-1 -: 2]);
    fold      = turn - {turn_bias[TURN_W-1 -: 2], {(TURN_W-2){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= GAIN_INV;
      y_r[0] <= '0;
      z_r[0] <= CW'(signed'(fold));
      q_r[0] <= quad;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i+1] <= q_r[i];
        if (!z_r[i][CW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ATAN_TURNS[i];
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ATAN_TURNS[i];
        end
      end
    end
  end

  // undo the quarter turn exactly
  always_ff @(posedge clk) begin
    if (en) begin
      case (q_r[CORDIC_STEPS])
        QUAD_1: begin
          trig_r.c <= TRIG_W'(-y_r[CORDIC_STEPS]);
          trig_r.s <= TRIG_W'(x_r[CORDIC_STEPS]);
        end
        QUAD_2: begin
          trig_r.c <= TRIG_W'(-x_r[CORDIC_STEPS]);
          trig_r.s <= TRIG_W'(-y_r[CORDIC_STEPS]);
        end
        QUAD_3: begin
          trig_r.c <= TRIG_W'(y_r[CORDIC_STEPS]);
          trig_r.s <= TRIG_W'(-x_r[CORDIC_STEPS]);
        end
        default: begin
          trig_r.c <= TRIG_W'(x_r[CORDIC_STEPS]);
          trig_r.s <= TRIG_W'(y_r[CORDIC_STEPS]);
        end
      endcase
    end
  end

  assign trig_o = trig_r;

endmodule

[sv/ezr_matrix_merge.sv]
`timescale 1ns / 1ps
// Merge stage: combines the three lanes' sine/cosine pairs into the nine matrix entries.
module ezr_matrix_merge #(
  parameter int OUT_FRAC_BITS = ezr_pkg::OUT_FRAC_BITS_DEF,
  localparam int OW = OUT_FRAC_BITS + 2
) (
  input  logic                   clk,
  input  logic                   en,
  input  ezr_pkg::trig_t         roll_i,
  input  ezr_pkg::trig_t         pitch_i,
  input  ezr_pkg::trig_t         yaw_i,
  output logic [8:0][OW-1:0]     mat_o
);
  import ezr_pkg::*;

  localparam int SW = TRIG_W + 2;
  localparam int SH = Q_FRAC - OUT_FRAC_BITS;
  localparam logic signed [SW-1:0] RND  = (SW'(1) << SH) >>> 1;
  localparam logic signed [SW-1:0] LIM  = SW'(1) << OUT_FRAC_BITS;
  localparam logic signed [SW-1:0] NLIM = -LIM;

  typedef logic signed [TRIG_W-1:0] tv_t;

  // stage 1: pairwise products
  tv_t cycr_r, cysr_r, sycr_r, sysr_r, cycp_r, sycp_r, cpsr_r, cpcr_r, sysp_r, cysp_r;
  tv_t sr1_r, cr1_r, sp1_r;
  // stage 2: triple products, pass-through of the rest
  tv_t cycr2_r, cysr2_r, sycr2_r, sysr2_r, cycp2_r, sycp2_r, cpsr2_r, cpcr2_r, sp2_r;
  tv_t syspsr_r, syspcr_r, cyspsr_r, cyspcr_r;
  // stage 3: sums
  logic signed [SW-1:0] sum_r [0:8];
  // stage 4: rounded and saturated entries
  logic [8:0][OW-1:0] mat_r;

  function automatic logic [OW-1:0] to_out(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    r = (v + RND) >>> SH;
    if (r > LIM) r = LIM;
    else if (r < NLIM) r = NLIM;
    return r[OW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      cycr_r <= mul_q(yaw_i.c, roll_i.c);
      cysr_r <= mul_q(yaw_i.c, roll_i.s);
      sycr_r <= mul_q(yaw_i.s, roll_i.c);
      sysr_r <= mul_q(yaw_i.s, roll_i.s);
      cycp_r <= mul_q(yaw_i.c, pitch_i.c);
      sycp_r <= mul_q(yaw_i.s, pitch_i.c);
      cpsr_r <= mul_q(pitch_i.c, roll_i.s);
      cpcr_r <= mul_q(pitch_i.c, roll_i.c);
      sysp_r <= mul_q(yaw_i.s, pitch_i.s);
      cysp_r <= mul_q(yaw_i.c, pitch_i.s);
      sr1_r  <= roll_i.s;
      cr1_r  <= roll_i.c;
      sp1_r  <= pitch_i.s;

      cycr2_r  <= cycr_r;
      cysr2_r  <= cysr_r;
      sycr2_r  <= sycr_r;
      sysr2_r  <= sysr_r;
      cycp2_r  <= cycp_r;
      sycp2_r  <= sycp_r;
      cpsr2_r  <= cpsr_r;
      cpcr2_r  <= cpcr_r;
      sp2_r    <= sp1_r;
      syspsr_r <= mul_q(sysp_r, sr1_r);
      syspcr_r <= mul_q(sysp_r, cr1_r);
      cyspsr_r <= mul_q(cysp_r, sr1_r);
      cyspcr_r <= mul_q(cysp_r, cr1_r);

      sum_r[0] <= SW'(cycr2_r) - SW'(syspsr_r);
      sum_r[1] <= -SW'(sycp2_r);
      sum_r[2] <= SW'(cysr2_r) + SW'(syspcr_r);
      sum_r[3] <= SW'(sycr2_r) + SW'(cyspsr_r);
      sum_r[4] <= SW'(cycp2_r);
      sum_r[5] <= SW'(sysr2_r) - SW'(cyspcr_r);
      sum_r[6] <= -SW'(cpsr2_r);
      sum_r[7] <= SW'(sp2_r);
      sum_r[8] <= SW'(cpcr2_r);

      for (int k = 0; k < 9; k++) begin
        mat_r[k] <= to_out(sum_r[k]);
      end
    end
  end

  assign mat_o = mat_r;

endmodule

[sv/euler_zxy_to_rotation_matrix_unit.sv]
`timescale 1ns / 1ps
// Top level: ZXY Euler angles to rotation matrix, three CORDIC lanes and a merge stage.
//
// Takes roll, pitch and yaw as signed binary angles (2^(ANGLE_BITS-1) is pi) and returns the
// nine entries of R = Rz(yaw) * Rx(pitch) * Ry(roll) as signed Q2.OUT_FRAC_BITS values,
// rounded half up and saturated to +/- one. Each angle has its own pipelined CORDIC lane of
// CORDIC_STEPS stages, with a fold stage in front and a quadrant-fix stage behind, so the
// three sine/cosine pairs are formed side by side. The merge stage then forms the Q30
// products (two multiplier rounds), the sums, and the final rounding. One set of angles is
// taken every cycle while in_tready is high; the path from input transfer to output valid is
// the CORDIC lane depth plus four merge stages and the output register. No state is
// kept between items. An output register with a skid entry sits at the result side: the
// pipeline keeps moving while one finished result waits, and stalls only once the skid entry
// is also full, at which point in_tready drops (it is driven straight from a register).
module euler_zxy_to_rotation_matrix_unit #(
  parameter int ANGLE_BITS    = ezr_pkg::ANGLE_BITS_DEF,
  parameter int OUT_FRAC_BITS = ezr_pkg::OUT_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS  = ezr_pkg::CORDIC_STEPS_DEF,
  localparam int IN_W  = ((3 * ANGLE_BITS + 7) / 8) * 8,
  localparam int OW    = OUT_FRAC_BITS + 2,
  localparam int OUT_W = ((9 * OW + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // roll_angle, pitch_angle, yaw_angle, zero pad
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // r00, r01, r02, r10, r11, r12, r20, r21, r22, zero pad
);
  import ezr_pkg::*;

  localparam int LAT = CORDIC_STEPS + 6;  // lane plus merge depth

  logic               pipe_en;
  trig_t              roll_trig, pitch_trig, yaw_trig;
  logic [8:0][OW-1:0] mat;

  logic [LAT-1:0]     vld_r, vld_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               skid_valid_r, skid_valid_nxt;
  logic [8:0][OW-1:0] out_data_r, skid_data_r;
  logic               out_load, out_from_skid, skid_load;
  logic               p_valid;

  // pipeline moves whenever the skid entry is free
  assign pipe_en   = !skid_valid_r;
  assign in_tready = pipe_en;

  ezr_cordic_lane #(
    .ANGLE_BITS  (ANGLE_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_lane_roll (
    .clk   (clk),
    .en    (pipe_en),
    .angle (in_tdata[ANGLE_BITS-1:0]),
    .trig_o(roll_trig)
  );

  ezr_cordic_lane #(
    .ANGLE_BITS  (ANGLE_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_lane_pitch (
    .clk   (clk),
    .en    (pipe_en),
    .angle (in_tdata[2*ANGLE_BITS-1:ANGLE_BITS]),
    .trig_o(pitch_trig)
  );

  ezr_cordic_lane #(
    .ANGLE_BITS  (ANGLE_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_lane_yaw (
    .clk   (clk),
    .en    (pipe_en),
    .angle (in_tdata[3*ANGLE_BITS-1:2*ANGLE_BITS]),
    .trig_o(yaw_trig)
  );

  ezr_matrix_merge #(
    .OUT_FRAC_BITS(OUT_FRAC_BITS)
  ) u_merge (
    .clk    (clk),
    .en     (pipe_en),
    .roll_i (roll_trig),
    .pitch_i(pitch_trig),
    .yaw_i  (yaw_trig),
    .mat_o  (mat)
  );

  // item-valid chain alongside the datapath
  assign p_valid = vld_r[LAT-1];

  always_comb begin
    vld_nxt = pipe_en ? {vld_r[LAT-2:0], in_tvalid} : vld_r;
  end

  // output register plus one skid entry
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_load       = 1'b0;
    out_from_skid  = 1'b0;
    skid_load      = 1'b0;
    if (out_tready || !out_valid_r) begin
      out_load = 1'b1;
      if (skid_valid_r) begin
        out_from_skid  = 1'b1;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = p_valid;
      end
    end else if (p_valid && pipe_en) begin
      // output stalled: catch the tail item before it is lost
      skid_load      = 1'b1;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      vld_r        <= vld_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_from_skid ? skid_data_r : mat;
    end
    if (skid_load) begin
      skid_data_r <= mat;
    end
  end

  assign out_tvalid = out_valid_r;

  always_comb begin
    out_tdata          = '0;
    out_tdata[9*OW-1:0] = out_data_r;
  end

endmodule

[sv/ezr_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the Euler-to-matrix unit, bound to the top level.
module ezr_checker #(
  parameter int OUT_FRAC_BITS = ezr_pkg::OUT_FRAC_BITS_DEF,
  parameter int OUT_W         = 144
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);
  localparam int OW   = OUT_FRAC_BITS + 2;
  localparam int LIM  = 1 << OUT_FRAC_BITS;
  localparam int NLIM = -LIM;

  // all nine entries within +/- one
  function automatic logic entries_in_range(input logic [OUT_W-1:0] d);
    logic                 ok;
    logic signed [OW-1:0] e;
    ok = 1'b1;
    for (int k = 0; k < 9; k++) begin
      e = d[k*OW +: OW];
      if ((e > LIM) || (e < NLIM)) ok = 1'b0;
    end
    return ok;
  endfunction

  // held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("ezr: result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("ezr: stalled result changed");

  // reset empties the result side
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("ezr: result valid after reset");

  // back-pressure only appears after a result was refused
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(in_tready) |-> $past(out_tvalid && !out_tready))
    else $error("ezr: input stalled without output back-pressure");

  // entries never leave +/- one
  a_entry_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> entries_in_range(out_tdata))
    else $error("ezr: matrix entry out of range");

endmodule

bind euler_zxy_to_rotation_matrix_unit ezr_checker #(
  .OUT_FRAC_BITS(OUT_FRAC_BITS),
  .OUT_W        (OUT_W)
) u_ezr_checker (.*);

[tb/ezr_matrix_checker.sv]
`timescale 1ns / 1ps
// Checker for the ZXY Euler-to-matrix unit: bit-exact matrix prediction and in-order compare.
module ezr_matrix_checker #(
  parameter int ANGLE_BITS    = ezr_pkg::ANGLE_BITS_DEF,
  parameter int OUT_FRAC_BITS = ezr_pkg::OUT_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS  = ezr_pkg::CORDIC_STEPS_DEF,
  localparam int IN_W  = ((3 * ANGLE_BITS + 7) / 8) * 8,
  localparam int OW    = OUT_FRAC_BITS + 2,
  localparam int OUT_W = ((9 * OW + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // roll_angle, pitch_angle, yaw_angle, zero pad
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [OUT_W-1:0] out_tdata,  // r00, r01, r02, r10, r11, r12, r20, r21, r22, zero pad
  output int               fail_count,
  output int               pending,
  output int               checked
);

  typedef logic [8:0][OW-1:0] matrix_t;

  localparam longint GAIN_INV_Q30 = 64'sd652032874;
  localparam int     RND_SH       = 30 - OUT_FRAC_BITS;
  localparam longint UNITY        = 64'sd1 <<< OUT_FRAC_BITS;

  // atan(2^-i) in units of 2^-32 turn
  localparam longint ATAN_TURN [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0
  };

  localparam string ENTRY_NAME [9] = '{
    "r00", "r01", "r02", "r10", "r11", "r12", "r20", "r21", "r22"
  };

  matrix_t pending_matrices [$];

  // Q30 x Q30 -> Q30, half rounds up
  function automatic longint q30_mul(input longint a, input longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // Q30 -> Q2.OUT_FRAC_BITS, rounded half up and clamped to +/- one
  function automatic logic [OW-1:0] q30_to_entry(input longint v);
    longint r;
    r = (v + (64'sd1 <<< (RND_SH - 1))) >>> RND_SH;
    if (r > UNITY) r = UNITY;
    if (r < -UNITY) r = -UNITY;
    return OW'(r);
  endfunction

  // Fold by quarter turns into [-pi/4, pi/4), rotate, then undo the fold
  function automatic void cordic_sin_cos(input logic [ANGLE_BITS-1:0] ang,
                                         output longint c, output longint s);
    logic [31:0]     turn;
    logic [31:0]     folded;
    ezr_pkg::quad_t  quad;
    longint          x;
    longint          y;
    longint          z;
    longint          dx;
    longint          dy;
    turn   = 32'(ang) << (32 - ANGLE_BITS);
    quad   = ezr_pkg::quad_t'((turn + 32'h2000_0000) >> 30);
    folded = turn - (32'(quad) << 30);
    z = longint'(signed'(folded));
    x = GAIN_INV_Q30;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TURN[i % 32];
      end else begin
        x += dx; y -= dy; z += ATAN_TURN[i % 32];
      end
    end
    case (quad)
      ezr_pkg::QUAD_1: begin c = -y; s = x;  end
      ezr_pkg::QUAD_2: begin c = -x; s = -y; end
      ezr_pkg::QUAD_3: begin c = y;  s = -x; end
      default:         begin c = x;  s = y;  end
    endcase
  endfunction

  function automatic matrix_t rotation_from_angles(input logic [IN_W-1:0] d);
    longint  cr, sr, cp, sp, cy, sy;
    longint  sysp, cysp;
    matrix_t m;
    cordic_sin_cos(d[0 +: ANGLE_BITS], cr, sr);
    cordic_sin_cos(d[ANGLE_BITS +: ANGLE_BITS], cp, sp);
    cordic_sin_cos(d[2*ANGLE_BITS +: ANGLE_BITS], cy, sy);
    sysp = q30_mul(sy, sp);
    cysp = q30_mul(cy, sp);
    m[0] = q30_to_entry(q30_mul(cy, cr) - q30_mul(sysp, sr));
    m[1] = q30_to_entry(-q30_mul(sy, cp));
    m[2] = q30_to_entry(q30_mul(cy, sr) + q30_mul(sysp, cr));
    m[3] = q30_to_entry(q30_mul(sy, cr) + q30_mul(cysp, sr));
    m[4] = q30_to_entry(q30_mul(cy, cp));
    m[5] = q30_to_entry(q30_mul(sy, sr) - q30_mul(cysp, cr));
    m[6] = q30_to_entry(-q30_mul(cp, sr));
    m[7] = q30_to_entry(sp);
    m[8] = q30_to_entry(q30_mul(cp, cr));
    return m;
  endfunction

  always @(posedge clk) begin
    matrix_t want;
    matrix_t got;
    int      errs;
    if (!rst_n) begin
      pending_matrices.delete();
      fail_count <= 0;
      pending    <= 0;
      checked    <= 0;
    end else begin
      errs = 0;
      if (in_tvalid && in_tready)
        pending_matrices.push_back(rotation_from_angles(in_tdata));
      if (out_tvalid && out_tready) begin
        got = out_tdata[9*OW-1:0];
        if (pending_matrices.size() == 0) begin
          $error("matrix transfer with no angle set outstanding");
          errs++;
        end else begin
          want = pending_matrices.pop_front();
          checked <= checked + 1;
          for (int i = 0; i < 9; i++) begin
            if (got[i] !== want[i]) begin
              $error("%s: expected %0d, got %0d", ENTRY_NAME[i],
                     signed'(want[i]), signed'(got[i]));
              errs++;
            end
          end
        end
      end
      fail_count <= fail_count + errs;
      pending    <= pending_matrices.size();
    end
  end

endmodule

[tb/tb_euler_zxy_to_rotation_matrix_unit.sv]
`timescale 1ns / 1ps
// Testbench top for the ZXY Euler-to-matrix unit: stimulus, flow control and verdict.
module tb_euler_zxy_to_rotation_matrix_unit;

  localparam int AB         = ezr_pkg::ANGLE_BITS_DEF;
  localparam int IN_W       = ((3 * AB + 7) / 8) * 8;
  localparam int OW         = ezr_pkg::OUT_FRAC_BITS_DEF + 2;
  localparam int OUT_W      = ((9 * OW + 7) / 8) * 8;
  // input transfer to output valid: lane and merge depth plus the output register
  localparam int PIPE_DEPTH = ezr_pkg::CORDIC_STEPS_DEF + 7;
  localparam int N_RANDOM   = 1800;
  // window of random items run with both sides flat out
  localparam int STEADY_LO  = 700;
  localparam int STEADY_HI  = 1000;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata   = '0;   // roll_angle, pitch_angle, yaw_angle, zero pad
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;         // r00, r01, r02, r10, r11, r12, r20, r21, r22, zero pad

  int fail_count;
  int pending;
  int checked;
  int angle_sets_sent = 0;
  int n_directed;
  bit steady = 1'b0;   // suppresses idling on both sides

  euler_zxy_to_rotation_matrix_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  ezr_matrix_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run (~1.8k items, ~23% gaps and stalls)
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // Result side: back-pressure about 23% of the time, none during the steady window
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 23);
  end

  // One transfer on the input channel, with random idle cycles in front of it.
  // Only one NBA to in_tvalid per edge: gaps lower it, the transfer raises it.
  task automatic send_angles(input logic [AB-1:0] roll, input logic [AB-1:0] pitch,
                             input logic [AB-1:0] yaw);
    while (!steady && $urandom_range(99) < 23) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'({yaw, pitch, roll});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    angle_sets_sent++;
  endtask

  // Mostly full-range angles; a share sits on the fold and quadrant boundaries
  // (multiples of pi/4, give or take a few LSBs) or on the extremes.
  function automatic logic [AB-1:0] random_angle(input int mode);
    logic [AB-1:0] a;
    if (mode < 55) begin
      a = AB'($urandom);
    end else if (mode < 85) begin
      a = AB'($urandom_range(7) * 8192 + $urandom_range(6) - 3);
    end else begin
      case ($urandom_range(4))
        0:       a = 16'h8000;  // minus pi
        1:       a = 16'h7fff;
        2:       a = 16'h0000;
        3:       a = 16'hffff;
        default: a = AB'($urandom);
      endcase
    end
    return a;
  endfunction

  initial begin
    int mode;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero, both ends of the range (minus pi wraps to pi), single-axis
    // quarter turns, the fold boundaries at +/- pi/4 and odd bit patterns.
    // All-zero angles give unity entries, the place where clamping can bite.
    send_angles(16'h0000, 16'h0000, 16'h0000);
    send_angles(16'h8000, 16'h8000, 16'h8000);
    send_angles(16'h7fff, 16'h7fff, 16'h7fff);
    send_angles(16'h4000, 16'h0000, 16'h0000);
    send_angles(16'h0000, 16'h4000, 16'h0000);
    send_angles(16'h0000, 16'h0000, 16'h4000);
    send_angles(16'hc000, 16'hc000, 16'hc000);
    send_angles(16'h2000, 16'h2000, 16'h2000);
    send_angles(16'he000, 16'he000, 16'he000);
    send_angles(16'h1fff, 16'hdfff, 16'h5fff);
    send_angles(16'h6000, 16'ha000, 16'h8001);
    send_angles(16'h5555, 16'haaaa, 16'h0001);
    send_angles(16'haaaa, 16'h5555, 16'hffff);
    send_angles(16'h8000, 16'h0000, 16'h7fff);
    n_directed = angle_sets_sent;

    for (int i = 0; i < N_RANDOM; i++) begin
      steady = (i >= STEADY_LO && i < STEADY_HI);
      mode = $urandom_range(99);
      send_angles(random_angle(mode), random_angle(mode), random_angle(mode));
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;
    @(posedge clk);

    // drain, then wait for anything stray
    while (pending != 0) @(posedge clk);
    repeat (2 * PIPE_DEPTH) @(posedge clk);

    $display("covered %0d angle sets (%0d directed) and compared %0d matrices",
             angle_sets_sent, n_directed, checked);
    $display("incl. fold and quadrant boundaries, full-scale angles, random gaps and stalls");
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
